FILE: rtl/woc_pkg.sv
// Package for the write owner conflict monitor.
// Holds request and outcome codes, register indexes and shared row types.
// No dependencies.
`default_nettype none

package woc_pkg;

    localparam logic [1:0] REQ_ACCESS     = 2'd0;
    localparam logic [1:0] REQ_END_BUCKET = 2'd1;
    localparam logic [1:0] REQ_QUERY      = 2'd2;

    localparam logic [2:0] OUT_HIT       = 3'd0;
    localparam logic [2:0] OUT_MISS      = 3'd1;
    localparam logic [2:0] OUT_UNCOUNTED = 3'd2;
    localparam logic [2:0] OUT_DROPPED   = 3'd3;
    localparam logic [2:0] OUT_FULL_HIT  = 3'd4;
    localparam logic [2:0] OUT_DONE      = 3'd5;

    localparam logic CFG_CORE_COUNT   = 1'b0;
    localparam logic CFG_STREAM_COUNT = 1'b1;

    localparam logic [8:0] CORE_COUNT_RST   = 9'd16;
    localparam logic [6:0] STREAM_COUNT_RST = 7'd64;

    localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
    localparam logic [15:0] RATIO_MAX = 16'hFFFF;

    typedef struct packed {
        logic [47:0] tag;
        logic [7:0]  core;
    } owner_entry_t;

    typedef struct packed {
        logic [31:0] hits;
        logic [31:0] misses;
    } stat_row_t;

endpackage

`default_nettype wire

FILE: rtl/woc_owner_table.sv
// Owner table storage: line tag and owning core per entry.
// One write port and one registered read port; uses woc_pkg.
`default_nettype none

module woc_owner_table #(
    parameter int ENTRIES = 64,
    parameter int IDX_W   = 6
) (
    input  wire                       clk,
    input  wire                       rd_en,
    input  wire  [IDX_W-1:0]          rd_addr,
    output woc_pkg::owner_entry_t     rd_entry,
    input  wire                       wr_en,
    input  wire  [IDX_W-1:0]          wr_addr,
    input  woc_pkg::owner_entry_t     wr_entry
);

    woc_pkg::owner_entry_t mem [ENTRIES];
    woc_pkg::owner_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

FILE: rtl/woc_stat_mem.sv
// Per-stream hit and miss counter storage.
// One write port and one registered read port; uses woc_pkg.
`default_nettype none

module woc_stat_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire                    clk,
    input  wire                    rd_en,
    input  wire  [ADDR_W-1:0]      rd_addr,
    output woc_pkg::stat_row_t     rd_row,
    input  wire                    wr_en,
    input  wire  [ADDR_W-1:0]      wr_addr,
    input  woc_pkg::stat_row_t     wr_row
);

    woc_pkg::stat_row_t mem [DEPTH];
    woc_pkg::stat_row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

FILE: rtl/woc_ratio_div.sv
// Restoring divider for the conflict ratio: num * 2^16 / den, one bit a cycle.
// Needs num < den for an exact 16-bit quotient; no package dependencies.
`default_nettype none

module woc_ratio_div (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [31:0] num,
    input  wire  [32:0] den,
    output logic        done,
    output logic [15:0] quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [15:0] quot_reg, quot_next;

    logic [33:0] shifted;
    logic [33:0] diff;
    logic        fits;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            rem_next  = {1'b0, num};
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[32:0] : shifted[32:0];
            quot_next = {quot_reg[14:0], fits};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

FILE: rtl/write_owner_conflict_monitor.sv
// Top level of the write owner conflict monitor: sequencer, config and result register.
// Uses woc_pkg, woc_owner_table, woc_stat_mem and woc_ratio_div.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-------------------
//  config  | cfg_we, cfg_index, cfg_data                      | write when cfg_we
//  input   | req_type, core_id, stream_index, line_address,   | in_valid/in_ready
//          | is_write                                         |
//  output  | outcome, hit_count, miss_count, conflict_ratio   | out_valid/out_ready
//
// An access scans the owner table through one tag comparator, one entry per cycle,
// until an entry matches or all owned lines (fill) have been read. A query starts the
// 16-step divider and waits for its quotient; end of bucket goes straight to the result.
// The next transaction can be accepted in the cycle after the result loads.
// After reset the counter memory is cleared, one stream a cycle, through all MAX_STREAMS rows;
// in_ready stays low meanwhile. A result waiting on out_ready holds the next
// transaction in the finish state.
`default_nettype none

module write_owner_conflict_monitor #(
    parameter int OWNER_ENTRIES = 64,
    parameter int MAX_STREAMS   = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [8:0]  cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  req_type,
    input  wire  [7:0]  core_id,
    input  wire  [5:0]  stream_index,
    input  wire  [47:0] line_address,
    input  wire         is_write,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  outcome,
    output logic [31:0] hit_count,
    output logic [31:0] miss_count,
    output logic [15:0] conflict_ratio
);

    localparam int IDX_W = $clog2(OWNER_ENTRIES);
    localparam int CNT_W = $clog2(OWNER_ENTRIES + 1);
    localparam int SW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(OWNER_ENTRIES);
    localparam logic [SW-1:0]    CLR_LAST   = SW'(MAX_STREAMS - 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_QUERY  = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [8:0]         core_count_reg, core_count_next;
    logic [6:0]         stream_count_reg, stream_count_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0]      clr_idx_reg, clr_idx_next;
    logic               out_valid_reg, out_valid_next;

    logic [7:0]         core_reg, core_next;
    logic [5:0]         sidx_reg, sidx_next;
    logic [47:0]        line_reg, line_next;
    logic               wr_reg, wr_next;
    logic [2:0]         res_outcome_reg, res_outcome_next;
    logic [31:0]        res_hits_reg, res_hits_next;
    logic [31:0]        res_misses_reg, res_misses_next;
    logic [15:0]        res_ratio_reg, res_ratio_next;
    logic [2:0]         outcome_reg, outcome_next;
    logic [31:0]        hit_count_reg, hit_count_next;
    logic [31:0]        miss_count_reg, miss_count_next;
    logic [15:0]        conflict_ratio_reg, conflict_ratio_next;

    logic                   accept;
    logic                   core_ok;
    logic                   stream_ok;
    logic [SW+5:0]          sidx_in_wide;
    logic [SW+5:0]          sidx_reg_wide;
    logic                   issue;
    logic                   match;

    logic                   own_rd_en;
    logic [IDX_W-1:0]       own_rd_addr;
    woc_pkg::owner_entry_t  own_rd_entry;
    logic                   own_wr_en;
    woc_pkg::owner_entry_t  own_wr_entry;

    logic                   stat_wr_en;
    logic [SW-1:0]          stat_wr_addr;
    woc_pkg::stat_row_t     stat_wr_row;
    woc_pkg::stat_row_t     stat_rd_row;
    woc_pkg::stat_row_t     stat_inc_hit;
    woc_pkg::stat_row_t     stat_inc_miss;

    logic                   div_start;
    logic [32:0]            div_den;
    logic                   div_done;
    logic [15:0]            div_quot;

    assign in_ready      = (state_reg == ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign sidx_in_wide  = {{SW{1'b0}}, stream_index};
    assign sidx_reg_wide = {{SW{1'b0}}, sidx_reg};
    assign core_ok       = {1'b0, core_id} < core_count_reg;
    assign stream_ok     = ({1'b0, stream_index} < stream_count_reg)
                           && (32'(stream_index) < 32'(MAX_STREAMS));

    assign issue        = scan_idx_reg < fill_reg;
    assign match        = cmp_vld_reg && (own_rd_entry.tag == line_reg);
    assign own_rd_en    = (state_reg == ST_SCAN) && issue;
    assign own_rd_addr  = scan_idx_reg[IDX_W-1:0];
    assign own_wr_entry = '{tag: line_reg, core: core_reg};

    assign stat_inc_hit.hits     = (stat_rd_row.hits == woc_pkg::SAT32) ?
                                   stat_rd_row.hits : stat_rd_row.hits + 32'd1;
    assign stat_inc_hit.misses   = stat_rd_row.misses;
    assign stat_inc_miss.hits    = stat_rd_row.hits;
    assign stat_inc_miss.misses  = (stat_rd_row.misses == woc_pkg::SAT32) ?
                                   stat_rd_row.misses : stat_rd_row.misses + 32'd1;

    assign div_den = {1'b0, stat_rd_row.hits} + {1'b0, stat_rd_row.misses};

    always_comb
    begin
        state_next          = state_reg;
        core_count_next     = core_count_reg;
        stream_count_next   = stream_count_reg;
        fill_next           = fill_reg;
        scan_idx_next       = scan_idx_reg;
        cmp_vld_next        = 1'b0;
        clr_idx_next        = clr_idx_reg;
        out_valid_next      = out_valid_reg;
        core_next           = core_reg;
        sidx_next           = sidx_reg;
        line_next           = line_reg;
        wr_next             = wr_reg;
        res_outcome_next    = res_outcome_reg;
        res_hits_next       = res_hits_reg;
        res_misses_next     = res_misses_reg;
        res_ratio_next      = res_ratio_reg;
        outcome_next        = outcome_reg;
        hit_count_next      = hit_count_reg;
        miss_count_next     = miss_count_reg;
        conflict_ratio_next = conflict_ratio_reg;
        own_wr_en           = 1'b0;
        stat_wr_en          = 1'b0;
        stat_wr_addr        = sidx_reg_wide[SW-1:0];
        stat_wr_row         = stat_inc_hit;
        div_start           = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                woc_pkg::CFG_CORE_COUNT:   core_count_next   = cfg_data;
                woc_pkg::CFG_STREAM_COUNT: stream_count_next = cfg_data[6:0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                stat_wr_en   = 1'b1;
                stat_wr_addr = clr_idx_reg;
                stat_wr_row  = '0;
                clr_idx_next = clr_idx_reg + SW'(1);
                if (clr_idx_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    core_next        = core_id;
                    sidx_next        = stream_index;
                    line_next        = line_address;
                    wr_next          = is_write;
                    res_outcome_next = woc_pkg::OUT_DROPPED;
                    res_hits_next    = '0;
                    res_misses_next  = '0;
                    res_ratio_next   = '0;
                    state_next       = ST_FINISH;
                    case (req_type)
                        woc_pkg::REQ_END_BUCKET:
                        begin
                            fill_next        = '0;
                            res_outcome_next = woc_pkg::OUT_DONE;
                        end
                        woc_pkg::REQ_QUERY:
                        begin
                            if (stream_ok)
                            begin
                                state_next = ST_QUERY;
                            end
                        end
                        woc_pkg::REQ_ACCESS:
                        begin
                            if (core_ok && stream_ok)
                            begin
                                scan_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    stat_wr_en = 1'b1;
                    state_next = ST_FINISH;
                    if (wr_reg && (own_rd_entry.core != core_reg))
                    begin
                        stat_wr_row      = stat_inc_miss;
                        res_outcome_next = woc_pkg::OUT_MISS;
                    end
                    else
                    begin
                        res_outcome_next = woc_pkg::OUT_HIT;
                    end
                end
                else if (!issue)
                begin
                    state_next = ST_FINISH;
                    if (!wr_reg)
                    begin
                        res_outcome_next = woc_pkg::OUT_UNCOUNTED;
                    end
                    else
                    begin
                        stat_wr_en = 1'b1;
                        if (fill_reg != TABLE_FULL)
                        begin
                            own_wr_en        = 1'b1;
                            fill_next        = fill_reg + CNT_W'(1);
                            res_outcome_next = woc_pkg::OUT_HIT;
                        end
                        else
                        begin
                            res_outcome_next = woc_pkg::OUT_FULL_HIT;
                        end
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    cmp_vld_next  = 1'b1;
                end
            end
            ST_QUERY:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_outcome_next = woc_pkg::OUT_DONE;
                    res_hits_next    = stat_rd_row.hits;
                    res_misses_next  = stat_rd_row.misses;
                    if (stat_rd_row.misses == 32'd0)
                    begin
                        res_ratio_next = '0;
                    end
                    else if (stat_rd_row.hits == 32'd0)
                    begin
                        res_ratio_next = woc_pkg::RATIO_MAX;
                    end
                    else
                    begin
                        res_ratio_next = div_quot;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    outcome_next        = res_outcome_reg;
                    hit_count_next      = res_hits_reg;
                    miss_count_next     = res_misses_reg;
                    conflict_ratio_next = res_ratio_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            core_count_reg   <= woc_pkg::CORE_COUNT_RST;
            stream_count_reg <= woc_pkg::STREAM_COUNT_RST;
            fill_reg         <= '0;
            scan_idx_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            clr_idx_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            core_count_reg   <= core_count_next;
            stream_count_reg <= stream_count_next;
            fill_reg         <= fill_next;
            scan_idx_reg     <= scan_idx_next;
            cmp_vld_reg      <= cmp_vld_next;
            clr_idx_reg      <= clr_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        core_reg           <= core_next;
        sidx_reg           <= sidx_next;
        line_reg           <= line_next;
        wr_reg             <= wr_next;
        res_outcome_reg    <= res_outcome_next;
        res_hits_reg       <= res_hits_next;
        res_misses_reg     <= res_misses_next;
        res_ratio_reg      <= res_ratio_next;
        outcome_reg        <= outcome_next;
        hit_count_reg      <= hit_count_next;
        miss_count_reg     <= miss_count_next;
        conflict_ratio_reg <= conflict_ratio_next;
    end

    woc_owner_table #(
        .ENTRIES (OWNER_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_owner_table (
        .clk      (clk),
        .rd_en    (own_rd_en),
        .rd_addr  (own_rd_addr),
        .rd_entry (own_rd_entry),
        .wr_en    (own_wr_en),
        .wr_addr  (fill_reg[IDX_W-1:0]),
        .wr_entry (own_wr_entry)
    );

    woc_stat_mem #(
        .DEPTH  (MAX_STREAMS),
        .ADDR_W (SW)
    ) u_stat_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (sidx_in_wide[SW-1:0]),
        .rd_row  (stat_rd_row),
        .wr_en   (stat_wr_en),
        .wr_addr (stat_wr_addr),
        .wr_row  (stat_wr_row)
    );

    woc_ratio_div u_ratio_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (stat_rd_row.misses),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign hit_count      = hit_count_reg;
    assign miss_count     = miss_count_reg;
    assign conflict_ratio = conflict_ratio_reg;

endmodule

`default_nettype wire

FILE: test/woc_conflict_checker.sv
`timescale 1ns / 100ps
// Result checker for the write owner conflict monitor: keeps its own owner table and
// per-stream counters and compares every returned result with the predicted one.
// Uses woc_pkg; sits beside the block in write_owner_conflict_monitor_tb.
module woc_conflict_checker #(
    parameter int OWNER_ENTRIES = 64,
    parameter int MAX_STREAMS   = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [8:0]  cfg_data,
    input  wire         in_valid,
    input  wire         in_ready,
    input  wire  [1:0]  req_type,
    input  wire  [7:0]  core_id,
    input  wire  [5:0]  stream_index,
    input  wire  [47:0] line_address,
    input  wire         is_write,
    input  wire         out_valid,
    input  wire         out_ready,
    input  wire  [2:0]  outcome,
    input  wire  [31:0] hit_count,
    input  wire  [31:0] miss_count,
    input  wire  [15:0] conflict_ratio,
    output int          failures,
    output int          pending,
    output int          checked,
    output int          full_hits
);

    typedef struct packed {
        logic [2:0]  outcome;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [15:0] ratio;
    } monitor_result_t;

    monitor_result_t expected_results[$];

    logic [8:0]  core_limit;
    logic [6:0]  stream_limit;
    logic        owned[OWNER_ENTRIES];
    logic [47:0] owned_line[OWNER_ENTRIES];
    logic [7:0]  owner_of[OWNER_ENTRIES];
    logic [31:0] hit_tally[MAX_STREAMS];
    logic [31:0] miss_tally[MAX_STREAMS];

    function automatic logic [31:0] sat_bump(logic [31:0] v);
        return (v == woc_pkg::SAT32) ? v : v + 32'd1;
    endfunction

    function automatic logic stream_tracked(logic [5:0] s);
        return ({1'b0, s} < stream_limit) && (int'(s) < MAX_STREAMS);
    endfunction

    function automatic monitor_result_t predict_outcome(logic [1:0] kind, logic [7:0] core,
            logic [5:0] strm, logic [47:0] line, logic wr);
        monitor_result_t r;
        int i;
        int slot;
        int free_slot;
        logic [63:0] total;
        logic [63:0] quot;
        r = '0;
        r.outcome = woc_pkg::OUT_DROPPED;
        slot = -1;
        free_slot = -1;
        if (kind == woc_pkg::REQ_END_BUCKET)
        begin
            for (i = 0; i < OWNER_ENTRIES; i++)
                owned[i] = 1'b0;
            r.outcome = woc_pkg::OUT_DONE;
        end
        else if (kind == woc_pkg::REQ_QUERY)
        begin
            if (stream_tracked(strm))
            begin
                r.outcome = woc_pkg::OUT_DONE;
                r.hits = hit_tally[strm];
                r.misses = miss_tally[strm];
                total = {32'd0, r.hits} + {32'd0, r.misses};
                if (total != 64'd0)
                begin
                    quot = {16'd0, r.misses, 16'd0} / total;
                    r.ratio = (quot > {48'd0, woc_pkg::RATIO_MAX}) ? woc_pkg::RATIO_MAX
                                                                   : quot[15:0];
                end
            end
        end
        else if (kind == woc_pkg::REQ_ACCESS && {1'b0, core} < core_limit
                 && stream_tracked(strm))
        begin
            for (i = 0; i < OWNER_ENTRIES; i++)
                if (slot < 0 && owned[i] && owned_line[i] == line)
                    slot = i;
            if (slot >= 0)
            begin
                if (wr && owner_of[slot] != core)
                begin
                    miss_tally[strm] = sat_bump(miss_tally[strm]);
                    r.outcome = woc_pkg::OUT_MISS;
                end
                else
                begin
                    hit_tally[strm] = sat_bump(hit_tally[strm]);
                    r.outcome = woc_pkg::OUT_HIT;
                end
            end
            else if (!wr)
            begin
                r.outcome = woc_pkg::OUT_UNCOUNTED;
            end
            else
            begin
                hit_tally[strm] = sat_bump(hit_tally[strm]);
                for (i = 0; i < OWNER_ENTRIES; i++)
                    if (free_slot < 0 && !owned[i])
                        free_slot = i;
                if (free_slot >= 0)
                begin
                    owned[free_slot] = 1'b1;
                    owned_line[free_slot] = line;
                    owner_of[free_slot] = core;
                    r.outcome = woc_pkg::OUT_HIT;
                end
                else
                begin
                    r.outcome = woc_pkg::OUT_FULL_HIT;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        monitor_result_t want;
        int i;
        if (!rst_n)
        begin
            core_limit = woc_pkg::CORE_COUNT_RST;
            stream_limit = woc_pkg::STREAM_COUNT_RST;
            for (i = 0; i < OWNER_ENTRIES; i++)
            begin
                owned[i] = 1'b0;
                owned_line[i] = '0;
                owner_of[i] = '0;
            end
            for (i = 0; i < MAX_STREAMS; i++)
            begin
                hit_tally[i] = '0;
                miss_tally[i] = '0;
            end
            expected_results.delete();
            failures = 0;
            checked = 0;
            full_hits = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == woc_pkg::CFG_CORE_COUNT)
                    core_limit = cfg_data;
                else
                    stream_limit = cfg_data[6:0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no transaction waiting: outcome %0d", outcome);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("outcome", 32'(want.outcome), 32'(outcome));
                    check_field("hit_count", want.hits, hit_count);
                    check_field("miss_count", want.misses, miss_count);
                    check_field("conflict_ratio", 32'(want.ratio), 32'(conflict_ratio));
                    checked++;
                    if (want.outcome == woc_pkg::OUT_FULL_HIT)
                        full_hits++;
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_outcome(req_type, core_id, stream_index,
                                                           line_address, is_write));
        end
        pending = expected_results.size();
    end

endmodule

FILE: test/write_owner_conflict_monitor_tb.sv
`timescale 1ns / 100ps
// Testbench top for the write owner conflict monitor: clock, reset, register writes,
// request stimulus in bursts, result-side stalls and the final verdict.
// Uses woc_pkg, write_owner_conflict_monitor and woc_conflict_checker.
module write_owner_conflict_monitor_tb;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam int          LINE_SLOTS = 128;
    localparam logic [47:0] LINE_A     = 48'h0000_1234_5678;
    localparam logic [47:0] LINE_B     = 48'h8765_4321_0000;
    localparam logic [47:0] LINE_ONES  = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] LINE_ZERO  = 48'h0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [7:0]  core_id = '0;
    logic [5:0]  stream_index = '0;
    logic [47:0] line_address = '0;
    logic        is_write = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  outcome;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [15:0] conflict_ratio;

    int failures;
    int pending;
    int checked;
    int full_hits;

    logic [8:0]  core_limit = woc_pkg::CORE_COUNT_RST;
    logic [6:0]  stream_limit = woc_pkg::STREAM_COUNT_RST;
    logic [47:0] lines[LINE_SLOTS];
    int          line_count = 1;
    int          burst_left = 1;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          settings = 1;
    int          useful_total = 0;

    write_owner_conflict_monitor dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .core_id(core_id), .stream_index(stream_index),
        .line_address(line_address), .is_write(is_write),
        .out_valid(out_valid), .out_ready(out_ready),
        .outcome(outcome), .hit_count(hit_count), .miss_count(miss_count),
        .conflict_ratio(conflict_ratio)
    );

    woc_conflict_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .core_id(core_id), .stream_index(stream_index),
        .line_address(line_address), .is_write(is_write),
        .out_valid(out_valid), .out_ready(out_ready),
        .outcome(outcome), .hit_count(hit_count), .miss_count(miss_count),
        .conflict_ratio(conflict_ratio),
        .failures(failures), .pending(pending), .checked(checked), .full_hits(full_hits)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= ((stall_left % 7) > 1);
        endcase
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send(input logic [1:0] kind, input logic [7:0] core, input logic [5:0] strm,
                        input logic [47:0] line, input logic wr);
        int gap;
        @(negedge clk);
        req_type <= kind;
        core_id <= core;
        stream_index <= strm;
        line_address <= line;
        is_write <= wr;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
    endtask

    // hold the request side until every transaction has returned its result
    task automatic drain(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (extra)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == woc_pkg::CFG_CORE_COUNT)
            core_limit = value;
        else
            stream_limit = value[6:0];
    endtask

    function automatic logic [47:0] any_line();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic random_request(input int write_pct, input bit allow_bucket,
                                  output bit useful);
        int pick;
        int core_hi;
        int strm_hi;
        logic [7:0] core;
        logic [5:0] strm;
        core_hi = (core_limit == 0) ? 0 : ((core_limit > 256) ? 255 : core_limit - 1);
        strm_hi = (stream_limit == 0) ? 0 : ((stream_limit > 64) ? 63 : stream_limit - 1);
        core = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, (core_hi < 3) ? core_hi : 3))
                                          : 8'($urandom_range(0, core_hi));
        strm = 6'($urandom_range(0, strm_hi));
        pick = $urandom_range(0, 99);
        useful = 1'b1;
        if (pick < 72)
            send(woc_pkg::REQ_ACCESS, core, strm, lines[$urandom_range(0, line_count - 1)],
                 $urandom_range(0, 99) < write_pct);
        else if (pick < 82)
            send(woc_pkg::REQ_QUERY, 8'($urandom), strm, any_line(), 1'($urandom));
        else if (pick < 86 && allow_bucket)
            send(woc_pkg::REQ_END_BUCKET, 8'($urandom), 6'($urandom), any_line(),
                 1'($urandom));
        else
        begin
            useful = 1'b0;
            case ($urandom_range(0, 3))
                0: send(REQ_UNUSED, 8'($urandom), 6'($urandom), any_line(), 1'($urandom));
                1: send(woc_pkg::REQ_QUERY, 8'($urandom), 6'($urandom), any_line(),
                        1'($urandom));
                default: send(woc_pkg::REQ_ACCESS, 8'($urandom), 6'($urandom),
                              ($urandom_range(0, 1) == 1) ? any_line()
                                                          : lines[$urandom_range(0, line_count - 1)],
                              1'($urandom));
            endcase
        end
    endtask

    task automatic run_phase(input logic [8:0] cores, input logic [8:0] streams, input int pool,
                             input int items, input int write_pct, input bit allow_bucket);
        int done;
        int i;
        bit useful;
        drain(8);
        write_reg(woc_pkg::CFG_CORE_COUNT, cores);
        write_reg(woc_pkg::CFG_STREAM_COUNT, streams);
        settings++;
        line_count = pool;
        for (i = 0; i < pool; i++)
            lines[i] = any_line();
        done = 0;
        while (done < items)
        begin
            random_request(write_pct, allow_bucket, useful);
            if (useful)
                done++;
            if ($urandom_range(0, 99) == 0)
                drain(0);
        end
        useful_total += done;
    endtask

    initial
    begin
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        send(woc_pkg::REQ_ACCESS, 8'd1, 6'd2, LINE_A, 1'b1);
        send(woc_pkg::REQ_ACCESS, 8'd1, 6'd2, LINE_A, 1'b1);
        send(woc_pkg::REQ_ACCESS, 8'd5, 6'd3, LINE_A, 1'b0);
        send(woc_pkg::REQ_ACCESS, 8'd7, 6'd4, LINE_A, 1'b1);
        send(woc_pkg::REQ_QUERY, 8'd0, 6'd4, LINE_ZERO, 1'b0);
        send(woc_pkg::REQ_QUERY, 8'd0, 6'd2, LINE_ZERO, 1'b0);
        send(woc_pkg::REQ_QUERY, 8'd0, 6'd9, LINE_ZERO, 1'b0);
        send(woc_pkg::REQ_ACCESS, 8'd0, 6'd0, LINE_B, 1'b0);
        send(woc_pkg::REQ_ACCESS, 8'd15, 6'd63, LINE_ONES, 1'b1);
        send(woc_pkg::REQ_ACCESS, 8'd0, 6'd0, LINE_ZERO, 1'b1);
        send(woc_pkg::REQ_ACCESS, 8'd0, 6'd0, LINE_ONES, 1'b1);
        send(woc_pkg::REQ_ACCESS, 8'd16, 6'd0, LINE_A, 1'b1);
        send(woc_pkg::REQ_ACCESS, 8'd255, 6'd63, LINE_ONES, 1'b1);
        send(REQ_UNUSED, 8'd255, 6'd63, LINE_ONES, 1'b1);
        send(woc_pkg::REQ_END_BUCKET, 8'd0, 6'd0, LINE_ZERO, 1'b0);
        send(woc_pkg::REQ_ACCESS, 8'd0, 6'd0, LINE_ONES, 1'b0);
        send(woc_pkg::REQ_QUERY, 8'd0, 6'd0, LINE_ZERO, 1'b0);
        send(woc_pkg::REQ_QUERY, 8'd0, 6'd63, LINE_ONES, 1'b1);

        drain(8);
        write_reg(woc_pkg::CFG_CORE_COUNT, 9'd16);
        write_reg(woc_pkg::CFG_STREAM_COUNT, 9'd5);
        send(woc_pkg::REQ_QUERY, 8'd0, 6'd5, LINE_ZERO, 1'b0);
        send(woc_pkg::REQ_QUERY, 8'd0, 6'd4, LINE_ZERO, 1'b0);
        send(woc_pkg::REQ_ACCESS, 8'd15, 6'd5, LINE_B, 1'b1);
        send(woc_pkg::REQ_ACCESS, 8'd15, 6'd4, LINE_B, 1'b1);

        run_phase(9'd16, 9'd64, 12, 160, 50, 1'b1);
        run_phase(9'd1, 9'd1, 8, 50, 50, 1'b1);
        run_phase(9'd256, 9'd64, 100, 160, 85, 1'b0);
        run_phase(9'd0, 9'd0, 8, 20, 50, 1'b1);
        run_phase(9'd5, 9'd7, 10, 120, 40, 1'b1);
        run_phase(9'd511, 9'd127, 24, 120, 60, 1'b1);
        run_phase(woc_pkg::CORE_COUNT_RST, 9'(woc_pkg::STREAM_COUNT_RST), 16, 80, 50, 1'b1);

        drain(80);
        $display("Covered %0d register settings and %0d well-formed random requests;",
                 settings, useful_total);
        $display("%0d results compared, %0d of them writes to a full owner table.",
                 checked, full_hits);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
